// ===== hdl/hrhs_pkg.sv =====
// Package: shared types, codes and constants of the HTTP response header stripper.
`default_nettype none

package hrhs_pkg;

	localparam int unsigned LIMIT_W     = 16;
	localparam int unsigned COUNT_W     = 17;
	localparam int unsigned STATUS_W    = 10;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 16'd16384;
	localparam logic [STATUS_W-1:0] STATUS_MAX  = 10'd999;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Shortest limit that still lets the full magic through.
	localparam logic [LIMIT_W-1:0] MAGIC_LAST_POS = 16'd3;

	typedef enum logic [2:0] {
		PH_MAGIC   = 3'd0,
		PH_VERSION = 3'd1,
		PH_SPACES  = 3'd2,
		PH_DIGITS  = 3'd3,
		PH_HEADER  = 3'd4,
		PH_BODY    = 3'd5,
		PH_PASS    = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		OC_OK       = 3'd0,
		OC_NOT_HTTP = 3'd1,
		OC_TOO_BIG  = 3'd2,
		OC_TRUNC    = 3'd3,
		OC_NO_STAT  = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0]          out_byte;
		logic                is_body;
		outcome_t            outcome;
		logic [STATUS_W-1:0] http_status;
		logic                last;
	} result_item_t;

	// Result burst caused by one input byte: [report] [magic prefix] [data byte].
	typedef struct packed {
		logic                rep_v;
		outcome_t            rep_oc;
		logic [STATUS_W-1:0] rep_st;
		logic [1:0]          pfx_n;
		logic                byte_v;
		logic [7:0]          data;
	} burst_t;

	// "HTTP"
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h48;
			2'd1: b = 8'h54;
			2'd2: b = 8'h54;
			2'd3: b = 8'h50;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/http_response_header_stripper_core.sv =====
// Top level: HTTP response header stripper core.
// Usage:
//  - src channel: one stream byte per transfer (data_byte, end_of_stream).
//    end_of_stream marks the final byte; the parser then rearms for the next
//    stream while header_limit keeps its value.
//  - res channel: result items, either body/pass-through bytes (is_body=1)
//    or one status report (is_body=0, outcome, http_status). last flags the
//    final item caused by one source byte.
//  - cfg: cfg_wr_en/cfg_wr_data write header_limit; write only
//    while no results are pending.
// An accepted byte's result burst is loaded into the result register.
// Throughput: one byte per cycle while each byte yields at most one item
// and res_stall is low. A failed "HTTP" magic check yields report + up to
// three prefix bytes + the byte itself (up to five items, one per cycle
// while res_stall is low); src_stall is held high until the last of those
// is transferred. The result register sits between parser and output, so a
// new byte is taken in the same cycle the last pending item leaves.
// Reset: clears the parser to the magic check, drops pending results and sets
// header_limit to 16384. res_stall only holds the current item in place.
`default_nettype none

module http_response_header_stripper_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           src_valid,
	output logic                          src_stall,
	input  wire  hrhs_pkg::in_item_t      src_item,
	output logic                          res_valid,
	input  wire                           res_stall,
	output hrhs_pkg::result_item_t        res_item,
	input  wire                           cfg_wr_en,
	input  wire  [hrhs_pkg::LIMIT_W-1:0]  cfg_wr_data
);

	hrhs_pkg::burst_t burst;
	logic             can_load;
	logic             src_xfer;

	assign src_stall = !can_load;
	assign src_xfer  = src_valid && can_load;

	hrhs_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (src_xfer),
		.item        (src_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.burst       (burst)
	);

	hrhs_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (src_xfer),
		.burst     (burst),
		.can_load  (can_load),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

// ===== hdl/hrhs_parser.sv =====
// Parser: stream state, header limit register and per-byte result burst logic.
`default_nettype none

module hrhs_parser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              accept,
	input  wire  hrhs_pkg::in_item_t         item,
	input  wire                              cfg_wr_en,
	input  wire  [hrhs_pkg::LIMIT_W-1:0]     cfg_wr_data,
	output hrhs_pkg::burst_t                 burst
);

	hrhs_pkg::phase_t                 phase_q, phase_n;
	logic [1:0]                       mpos_q, mpos_n;
	logic [hrhs_pkg::STATUS_W-1:0]    st_q, st_n;
	logic [1:0]                       crlf_q, crlf_n;
	logic [hrhs_pkg::COUNT_W-1:0]     cnt_q, cnt_n;
	logic [hrhs_pkg::LIMIT_W-1:0]     limit_q;

	logic [7:0]  b;
	logic        eos;
	logic        digit;
	logic [3:0]  dval;
	logic [13:0] acc;
	logic [hrhs_pkg::STATUS_W-1:0] st_acc;
	logic        stop;
	logic        have;
	logic [7:0]  want;

	assign b     = item.data_byte;
	assign eos   = item.end_of_stream;
	assign digit = (b >= hrhs_pkg::CHAR_ZERO) && (b <= hrhs_pkg::CHAR_NINE);
	assign dval  = b[3:0];
	assign acc   = ({4'b0, st_q} << 3) + ({4'b0, st_q} << 1) + {10'b0, dval};
	assign st_acc = (acc > {4'b0, hrhs_pkg::STATUS_MAX}) ? hrhs_pkg::STATUS_MAX
		: acc[hrhs_pkg::STATUS_W-1:0];
	assign want  = crlf_q[0] ? hrhs_pkg::CHAR_LF : hrhs_pkg::CHAR_CR;

	always_comb begin
		phase_n = phase_q;
		mpos_n  = mpos_q;
		st_n    = st_q;
		crlf_n  = crlf_q;
		cnt_n   = cnt_q;
		burst   = '0;
		stop    = 1'b0;
		have    = 1'b0;

		unique case (phase_q)
			hrhs_pkg::PH_MAGIC: begin
				cnt_n = cnt_q + 1'b1;
				if (b == hrhs_pkg::magic_byte(mpos_q)) begin
					if (mpos_q == 2'd3) begin
						mpos_n  = 2'd0;
						phase_n = hrhs_pkg::PH_VERSION;
						if (limit_q < hrhs_pkg::MAGIC_LAST_POS) begin
							phase_n      = hrhs_pkg::PH_DONE;
							burst.rep_v  = 1'b1;
							burst.rep_oc = hrhs_pkg::OC_TOO_BIG;
						end
					end else begin
						mpos_n = mpos_q + 1'b1;
					end
				end else begin
					// report, then the matched prefix, then this byte
					burst.rep_v  = 1'b1;
					burst.rep_oc = hrhs_pkg::OC_NOT_HTTP;
					burst.pfx_n  = mpos_q;
					burst.byte_v = 1'b1;
					burst.data   = b;
					mpos_n       = 2'd0;
					phase_n      = hrhs_pkg::PH_PASS;
				end
			end
			hrhs_pkg::PH_VERSION, hrhs_pkg::PH_SPACES,
			hrhs_pkg::PH_DIGITS, hrhs_pkg::PH_HEADER: begin
				cnt_n = cnt_q + 1'b1;
				// status parse first
				if (phase_q == hrhs_pkg::PH_VERSION) begin
					if (b == hrhs_pkg::CHAR_SPACE) phase_n = hrhs_pkg::PH_SPACES;
				end else if (phase_q == hrhs_pkg::PH_SPACES) begin
					if (digit) begin
						st_n    = {6'b0, dval};
						phase_n = hrhs_pkg::PH_DIGITS;
					end else if (b != hrhs_pkg::CHAR_SPACE) begin
						phase_n      = hrhs_pkg::PH_DONE;
						burst.rep_v  = 1'b1;
						burst.rep_oc = hrhs_pkg::OC_NO_STAT;
						stop         = 1'b1;
					end
				end else if (phase_q == hrhs_pkg::PH_DIGITS) begin
					if (digit) begin
						st_n = st_acc;
					end else if (st_q == '0) begin
						phase_n      = hrhs_pkg::PH_DONE;
						burst.rep_v  = 1'b1;
						burst.rep_oc = hrhs_pkg::OC_NO_STAT;
						stop         = 1'b1;
					end else begin
						phase_n = hrhs_pkg::PH_HEADER;
					end
				end
				// then the size limit
				if (!stop && (cnt_q > {1'b0, limit_q})) begin
					phase_n      = hrhs_pkg::PH_DONE;
					burst.rep_v  = 1'b1;
					burst.rep_oc = hrhs_pkg::OC_TOO_BIG;
					burst.rep_st = st_n;
					stop         = 1'b1;
				end
				// then the blank-line match; a wrong byte restarts it
				if (!stop) begin
					if (b == want) begin
						if (crlf_q == 2'd3) begin
							burst.rep_v = 1'b1;
							if (phase_n == hrhs_pkg::PH_HEADER) begin
								phase_n      = hrhs_pkg::PH_BODY;
								burst.rep_oc = hrhs_pkg::OC_OK;
								burst.rep_st = st_n;
							end else begin
								phase_n      = hrhs_pkg::PH_DONE;
								burst.rep_oc = hrhs_pkg::OC_NO_STAT;
							end
						end else begin
							crlf_n = crlf_q + 1'b1;
						end
					end else begin
						crlf_n = 2'd0;
					end
				end
			end
			hrhs_pkg::PH_BODY, hrhs_pkg::PH_PASS: begin
				burst.byte_v = 1'b1;
				burst.data   = b;
			end
			hrhs_pkg::PH_DONE: begin
				// aborted: drop until end of stream
			end
			default: begin
			end
		endcase

		if (eos) begin
			// stream ended inside the header: report slot is free here
			if (phase_n == hrhs_pkg::PH_MAGIC || phase_n == hrhs_pkg::PH_VERSION ||
			    phase_n == hrhs_pkg::PH_SPACES || phase_n == hrhs_pkg::PH_DIGITS ||
			    phase_n == hrhs_pkg::PH_HEADER) begin
				have = (phase_n == hrhs_pkg::PH_HEADER) ||
					(phase_n == hrhs_pkg::PH_DIGITS && st_n != '0);
				burst.rep_v  = 1'b1;
				burst.rep_oc = have ? hrhs_pkg::OC_TRUNC : hrhs_pkg::OC_NO_STAT;
				burst.rep_st = have ? st_n : '0;
			end
			phase_n = hrhs_pkg::PH_MAGIC;
			mpos_n  = 2'd0;
			st_n    = '0;
			crlf_n  = 2'd0;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrhs_pkg::PH_MAGIC;
			mpos_q  <= 2'd0;
			st_q    <= '0;
			crlf_q  <= 2'd0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			mpos_q  <= mpos_n;
			st_q    <= st_n;
			crlf_q  <= crlf_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hrhs_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hrhs_emitter.sv =====
// Emitter: result burst register, serialized one item per transfer.
`default_nettype none

module hrhs_emitter (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      load,
	input  wire hrhs_pkg::burst_t    burst,
	output logic                     can_load,
	output logic                     res_valid,
	input  wire                      res_stall,
	output hrhs_pkg::result_item_t   res_item
);

	logic                          rep_v_q;
	hrhs_pkg::outcome_t            oc_q;
	logic [hrhs_pkg::STATUS_W-1:0] st_q;
	logic [1:0]                    pfx_left_q;
	logic [1:0]                    pfx_idx_q;
	logic                          byte_v_q;
	logic [7:0]                    byte_q;

	logic busy;
	logic xfer;
	logic is_last;

	assign busy      = rep_v_q || (pfx_left_q != 2'd0) || byte_v_q;
	assign res_valid = busy;
	assign xfer      = busy && !res_stall;
	assign can_load  = !busy || (xfer && is_last);

	always_comb begin
		res_item = '0;
		if (rep_v_q) begin
			is_last              = (pfx_left_q == 2'd0) && !byte_v_q;
			res_item.outcome     = oc_q;
			res_item.http_status = st_q;
		end else if (pfx_left_q != 2'd0) begin
			is_last           = (pfx_left_q == 2'd1) && !byte_v_q;
			res_item.is_body  = 1'b1;
			res_item.out_byte = hrhs_pkg::magic_byte(pfx_idx_q);
		end else begin
			is_last           = 1'b1;
			res_item.is_body  = 1'b1;
			res_item.out_byte = byte_q;
		end
		res_item.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_v_q    <= 1'b0;
			pfx_left_q <= 2'd0;
			pfx_idx_q  <= 2'd0;
			byte_v_q   <= 1'b0;
		end else if (load) begin
			rep_v_q    <= burst.rep_v;
			pfx_left_q <= burst.pfx_n;
			pfx_idx_q  <= 2'd0;
			byte_v_q   <= burst.byte_v;
		end else if (xfer) begin
			if (rep_v_q) begin
				rep_v_q <= 1'b0;
			end else if (pfx_left_q != 2'd0) begin
				pfx_left_q <= pfx_left_q - 1'b1;
				pfx_idx_q  <= pfx_idx_q + 1'b1;
			end else begin
				byte_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oc_q   <= burst.rep_oc;
			st_q   <= burst.rep_st;
			byte_q <= burst.data;
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the HTTP response header stripper core: directed table, random streams, checks.
module testbench;
	import hrhs_pkg::*;

	// Run shape
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned DRAIN_CYCLES = 8;     // idle time after the last due result, for bytes with no result
	localparam int unsigned CHOKE_CYCLES = 300;   // long receiver hold-off, fills the result path
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 410;
	localparam int unsigned N_PHASES     = 7;

	localparam logic [7:0] HTTP_TAG [4] = '{8'h48, 8'h54, 8'h54, 8'h50};

	// header_limit per random phase; 0 means "draw one"
	localparam logic [LIMIT_W-1:0] PHASE_LIMIT [N_PHASES] =
		'{16'd1, 16'd16, 16'd40, 16'd65535, 16'd2, 16'd0, 16'd0};

	// Directed table. A row either writes header_limit or offers one stream byte.
	// Rows marked typed carry the single result item they must produce; all other
	// rows are checked against the predictor.
	typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [7:0]         data;
		logic               eos;
		logic [LIMIT_W-1:0] limit;
		logic               typed;
		result_item_t       want;
	} row_t;

	localparam result_item_t NO_ITEM = '0;
	localparam int unsigned  N_ROWS  = 26;

	localparam row_t DIRECTED [N_ROWS] = '{
		// magic broken on its last byte: report, prefix "HTT", then the byte itself
		'{ROW_BYTE,  8'h48, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'hff, 1'b0, 16'd0,     1'b0, NO_ITEM},
		// passed-through byte that also closes the stream
		'{ROW_BYTE,  8'h00, 1'b1, 16'd0,     1'b1, '{8'h00, 1'b1, OC_OK, 10'd0, 1'b1}},
		// limit below three: the byte completing the magic overflows
		'{ROW_LIMIT, 8'h00, 1'b0, 16'd2,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h48, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h50, 1'b0, 16'd0,     1'b1, '{8'h00, 1'b0, OC_TOO_BIG, 10'd0, 1'b1}},
		// after an abort the rest of the stream is dropped
		'{ROW_BYTE,  8'hff, 1'b1, 16'd0,     1'b0, NO_ITEM},
		'{ROW_LIMIT, 8'h00, 1'b0, 16'd65535, 1'b0, NO_ITEM},
		// empty version word, code 9, stream ends inside the digits
		'{ROW_BYTE,  8'h48, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h50, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h20, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h39, 1'b1, 16'd0,     1'b1, '{8'h00, 1'b0, OC_TRUNC, 10'd9, 1'b1}},
		// code of zero ends the header on the first non-digit
		'{ROW_BYTE,  8'h48, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h54, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h50, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h20, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h30, 1'b0, 16'd0,     1'b0, NO_ITEM},
		'{ROW_BYTE,  8'h78, 1'b1, 16'd0,     1'b1, '{8'h00, 1'b0, OC_NO_STAT, 10'd0, 1'b1}},
		// stream ends inside the magic check
		'{ROW_BYTE,  8'h48, 1'b1, 16'd0,     1'b1, '{8'h00, 1'b0, OC_NO_STAT, 10'd0, 1'b1}}
	};

	// DUT-facing signals; the ones driven here are known from time zero
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                src_valid   = 1'b0;
	logic                src_stall;
	in_item_t            src_item    = '0;
	logic                res_valid;
	logic                res_stall   = 1'b0;
	result_item_t        res_item;
	logic                cfg_wr_en   = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wr_data = '0;

	// Traffic shaping
	logic        tx_quiet   = 1'b0;   // sender offers back to back
	logic        rx_quiet   = 1'b0;   // receiver never stalls on its own
	logic        choke_kick = 1'b0;   // starts the long receiver hold-off
	logic        choke      = 1'b0;
	int unsigned rx_run     = 0;

	// Scoreboard
	result_item_t due_results [$];
	int unsigned  errors = 0;
	int unsigned  cycles = 0;

	// Predictor state: parser phase, magic position, status code, CR LF progress,
	// header byte count and the limit register
	phase_t              ph_q      = PH_MAGIC;
	logic [1:0]          tag_pos   = '0;
	logic [STATUS_W-1:0] code_acc  = '0;
	logic [1:0]          crlf_seen = '0;
	logic [COUNT_W-1:0]  hdr_bytes = '0;
	logic [LIMIT_W-1:0]  limit_q   = LIMIT_RESET;

	// Result items caused by the byte just predicted
	result_item_t burst_items [5];
	int unsigned  burst_len = 0;

	http_response_header_stripper_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_item    (src_item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void add_result(input logic [7:0] data, input logic body,
			input outcome_t oc, input logic [STATUS_W-1:0] st);
		burst_items[burst_len] = '{out_byte: data, is_body: body, outcome: oc,
			http_status: st, last: 1'b0};
		burst_len++;
	endfunction

	// One byte while the header is being parsed. Order on a byte: status parse,
	// then the limit, then the CR LF match.
	function automatic void scan_header(input logic [7:0] data);
		int unsigned pos;
		int unsigned acc;
		logic        digit;
		logic [7:0]  want;
		pos   = int'(hdr_bytes);
		digit = (data >= CHAR_ZERO) && (data <= CHAR_NINE);
		hdr_bytes++;
		case (ph_q)
			PH_VERSION: begin
				if (data == CHAR_SPACE) ph_q = PH_SPACES;
			end
			PH_SPACES: begin
				if (digit) begin
					code_acc = 10'(data - CHAR_ZERO);
					ph_q = PH_DIGITS;
				end else if (data != CHAR_SPACE) begin
					// no digit where the code belongs
					ph_q = PH_DONE;
					add_result(8'h00, 1'b0, OC_NO_STAT, '0);
					return;
				end
			end
			PH_DIGITS: begin
				if (digit) begin
					acc = 32'(code_acc) * 10 + 32'(data - CHAR_ZERO);
					code_acc = (acc > 32'(STATUS_MAX)) ? STATUS_MAX : 10'(acc);
				end else if (code_acc == '0) begin
					ph_q = PH_DONE;
					add_result(8'h00, 1'b0, OC_NO_STAT, '0);
					return;
				end else begin
					ph_q = PH_HEADER;
				end
			end
			default: ;
		endcase
		if (pos > int'(limit_q)) begin
			ph_q = PH_DONE;
			add_result(8'h00, 1'b0, OC_TOO_BIG, code_acc);
			return;
		end
		want = crlf_seen[0] ? CHAR_LF : CHAR_CR;
		if (data == want) begin
			if (crlf_seen == 2'd3) begin
				// header end; without a parsed code it counts as no status
				if (ph_q == PH_HEADER) begin
					ph_q = PH_BODY;
					add_result(8'h00, 1'b0, OC_OK, code_acc);
				end else begin
					ph_q = PH_DONE;
					add_result(8'h00, 1'b0, OC_NO_STAT, '0);
				end
				return;
			end
			crlf_seen++;
		end else begin
			// a wrong byte drops the match and is not taken as a new CR
			crlf_seen = '0;
		end
	endfunction

	// Fills burst_items with what one stream byte must produce.
	function automatic void predict_strip(input logic [7:0] data, input logic eos);
		logic have_code;
		burst_len = 0;
		case (ph_q)
			PH_MAGIC: begin
				hdr_bytes++;
				if (data == HTTP_TAG[tag_pos]) begin
					if (tag_pos == 2'd3) begin
						tag_pos = '0;
						ph_q = PH_VERSION;
						if (limit_q < MAGIC_LAST_POS) begin
							ph_q = PH_DONE;
							add_result(8'h00, 1'b0, OC_TOO_BIG, '0);
						end
					end else begin
						tag_pos++;
					end
				end else begin
					// report, then the part of the magic that did match, then this byte
					add_result(8'h00, 1'b0, OC_NOT_HTTP, '0);
					for (int i = 0; i < int'(tag_pos); i++)
						add_result(HTTP_TAG[i], 1'b1, OC_OK, '0);
					add_result(data, 1'b1, OC_OK, '0);
					tag_pos = '0;
					ph_q = PH_PASS;
				end
			end
			PH_VERSION, PH_SPACES, PH_DIGITS, PH_HEADER: scan_header(data);
			PH_BODY, PH_PASS: add_result(data, 1'b1, OC_OK, '0);
			default: ;
		endcase
		if (eos) begin
			if (ph_q <= PH_HEADER) begin
				have_code = (ph_q == PH_HEADER) || (ph_q == PH_DIGITS && code_acc != '0);
				if (have_code)
					add_result(8'h00, 1'b0, OC_TRUNC, code_acc);
				else
					add_result(8'h00, 1'b0, OC_NO_STAT, '0);
			end
			// rearm for the next stream; the limit stays
			ph_q      = PH_MAGIC;
			tag_pos   = '0;
			code_acc  = '0;
			crlf_seen = '0;
			hdr_bytes = '0;
		end
		if (burst_len != 0) burst_items[burst_len-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------- traffic

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Header text: mostly printable, sometimes any byte
	function automatic logic [7:0] header_char();
		if ($urandom_range(3) == 0) return 8'($urandom);
		return 8'($urandom_range(32, 126));
	endfunction

	// Offers one byte, waits for its transfer, then books the expected results.
	// Valid stays high between back-to-back bytes.
	task automatic send_byte(input logic [7:0] data, input logic eos, input logic typed,
			input result_item_t want);
		int unsigned gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= '{data_byte: data, end_of_stream: eos};
		@(posedge clk);
		while (src_stall) @(posedge clk);
		predict_strip(data, eos);
		if (typed)
			due_results.push_back(want);
		else
			for (int i = 0; i < int'(burst_len); i++) due_results.push_back(burst_items[i]);
	endtask

	// Quiet point: everything delivered, plus a few cycles for bytes with no result.
	task automatic settle();
		src_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_q = value;
	endtask

	// One random stream: mostly well-formed responses with random content,
	// the rest non-HTTP streams and loose noise.
	task automatic send_stream(inout int unsigned sent);
		logic [7:0]  bytes_q [$];
		logic [7:0]  b;
		logic        eos_at_end;
		int unsigned pick;
		int unsigned k;
		int unsigned cut;
		pick = $urandom_range(99);
		eos_at_end = 1'b1;
		if (pick < 70) begin
			for (int i = 0; i < 4; i++) bytes_q.push_back(HTTP_TAG[i]);
			repeat ($urandom_range(0, 4)) bytes_q.push_back(8'($urandom_range(33, 126)));
			repeat ($urandom_range(1, 3)) bytes_q.push_back(CHAR_SPACE);
			case ($urandom_range(7))
				0: bytes_q.push_back(CHAR_ZERO);
				1: repeat (2) bytes_q.push_back(CHAR_ZERO);
				2: bytes_q.push_back(8'($urandom_range(58, 255)));
				default: repeat ($urandom_range(1, 5))
					bytes_q.push_back(8'($urandom_range(48, 57)));  // five digits saturate
			endcase
			if ($urandom_range(1) == 1) begin
				bytes_q.push_back(CHAR_SPACE);
				repeat ($urandom_range(0, 6)) bytes_q.push_back(header_char());
			end
			bytes_q.push_back(CHAR_CR);
			bytes_q.push_back(CHAR_LF);
			repeat ($urandom_range(0, 3)) begin
				repeat ($urandom_range(1, 12)) bytes_q.push_back(header_char());
				if ($urandom_range(5) == 0) bytes_q.push_back(CHAR_CR);  // stray CR breaks the match
				bytes_q.push_back(CHAR_CR);
				bytes_q.push_back(CHAR_LF);
			end
			bytes_q.push_back(CHAR_CR);
			bytes_q.push_back(CHAR_LF);
			repeat ($urandom_range(0, 10)) bytes_q.push_back(8'($urandom));
			if ($urandom_range(5) == 0) begin
				// cut short somewhere
				cut = $urandom_range(1, bytes_q.size());
				while (bytes_q.size() > cut) void'(bytes_q.pop_back());
			end
		end else if (pick < 85) begin
			k = $urandom_range(0, 3);
			for (int i = 0; i < int'(k); i++) bytes_q.push_back(HTTP_TAG[i]);
			do b = 8'($urandom); while (b == HTTP_TAG[k]);
			bytes_q.push_back(b);
			repeat ($urandom_range(0, 10)) bytes_q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom));
			eos_at_end = 1'($urandom_range(1));   // without it the next stream continues this one
		end
		foreach (bytes_q[i])
			send_byte(bytes_q[i], eos_at_end && (i == bytes_q.size() - 1), 1'b0, NO_ITEM);
		sent += bytes_q.size();
	endtask

	// ---------------------------------------------------------------- receiver

	// Random stall runs, suppressed in quiet phases, forced during the choke.
	always @(posedge clk) begin : drive_res_stall
		if (rx_run == 0 && !rx_quiet && $urandom_range(3) == 0) rx_run = pick_gap();
		if (choke || rx_run != 0)
			res_stall <= 1'b1;
		else
			res_stall <= 1'b0;
		if (rx_run != 0) rx_run--;
	end

	// Long hold-off, counted here while the sender keeps offering bytes.
	initial begin : hold_off_receiver
		wait (choke_kick);
		@(posedge clk);
		choke <= 1'b1;
		repeat (CHOKE_CYCLES) @(posedge clk);
		choke <= 1'b0;
	end

	// Each transfer on the result side is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		result_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: out_byte %0d is_body %0d outcome %0d status %0d",
					res_item.out_byte, res_item.is_body, res_item.outcome,
					res_item.http_status);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (res_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0d, got %0d", want.out_byte, res_item.out_byte);
					errors++;
				end
				if (res_item.is_body !== want.is_body) begin
					$error("is_body: expected %0d, got %0d", want.is_body, res_item.is_body);
					errors++;
				end
				if (res_item.outcome !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, res_item.outcome);
					errors++;
				end
				if (res_item.http_status !== want.http_status) begin
					$error("http_status: expected %0d, got %0d", want.http_status,
						res_item.http_status);
					errors++;
				end
				if (res_item.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res_item.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** http_response_header_stripper_core: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : stimulus
		int unsigned        sent;
		int unsigned        phase_end;
		logic [LIMIT_W-1:0] lim;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < int'(N_ROWS); i++) begin
			if (DIRECTED[i].kind == ROW_LIMIT)
				set_limit(DIRECTED[i].limit);
			else
				send_byte(DIRECTED[i].data, DIRECTED[i].eos, DIRECTED[i].typed,
					DIRECTED[i].want);
		end

		// Random phases, one header_limit each; the third one carries the choke.
		sent = 0;
		for (int p = 0; p < int'(N_PHASES); p++) begin
			lim = PHASE_LIMIT[p];
			if (lim == '0) lim = (p % 2 == 1) ? 16'($urandom_range(3, 60))
				: 16'($urandom_range(1, 65535));
			set_limit(lim);
			tx_quiet = ($urandom_range(3) == 0);
			rx_quiet = ($urandom_range(3) == 0);
			if (p == 2) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b0;
				choke_kick = 1'b1;
			end
			phase_end = RANDOM_ITEMS * (p + 1) / N_PHASES;
			while (sent < phase_end) send_stream(sent);
		end

		settle();
		if (errors == 0)
			$display("** http_response_header_stripper_core: PASSED **");
		else
			$display("** http_response_header_stripper_core: FAILED **");
		$finish;
	end

endmodule

// ===== http_response_header_stripper_core.f =====
hdl/hrhs_pkg.sv
hdl/hrhs_parser.sv
hdl/hrhs_emitter.sv
hdl/http_response_header_stripper_core.sv
tb/testbench.sv
